>>> hdl/dnh_pkg.sv
// ----------------------------------------------------------------------------
// dnh_pkg: shared types and constants for the directory name hash
// Holds the job handed from the byte packer to the mixing stage and the
// state type of the mixing sequencer.
// ----------------------------------------------------------------------------
package dnh_pkg;

  localparam int unsigned WordW     = 32;
  localparam int unsigned HashW     = 16;
  localparam int unsigned MixSteps  = 7;
  localparam int unsigned StepW     = 3;
  localparam int unsigned ShortLen  = 2;   // names this long or shorter hash to zero

  // One finished name: both accumulators after the final fold.
  typedef struct packed {
    logic [WordW-1:0] acc_a;
    logic [WordW-1:0] acc_b;
    logic             short_name;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DONE
  } back_state_t;

endpackage

>>> hdl/dnh_front.sv
// ----------------------------------------------------------------------------
// dnh_front: byte packer
// Packs sign-extended name bytes into words, folds them alternately into two
// accumulators and hands a finished name to the job queue on its last byte.
// ----------------------------------------------------------------------------
module dnh_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [7:0]        in_name_byte,
  input  logic              in_last_byte,
  output logic              job_push,
  output dnh_pkg::job_t     job,
  input  logic              job_full
);

  logic [dnh_pkg::WordW-1:0] acc_first_r, acc_first_nxt;
  logic [dnh_pkg::WordW-1:0] acc_second_r, acc_second_nxt;
  logic [dnh_pkg::WordW-1:0] word_r, word_nxt;
  logic [1:0]                slot_r, slot_nxt;
  logic                      to_second_r, to_second_nxt;
  logic [1:0]                len_r, len_nxt;

  logic                      accept;
  logic [dnh_pkg::WordW-1:0] word_sh;
  logic [dnh_pkg::WordW-1:0] word_pad;
  logic [1:0]                len_inc;
  logic                      do_fold;
  logic [dnh_pkg::WordW-1:0] fold_word;
  logic [dnh_pkg::WordW-1:0] acc_first_f, acc_second_f;

  assign full   = job_full;
  assign accept = push && !job_full;

  // Shift in the byte, sign-extended, ORed over the whole word.
  assign word_sh = {word_r[23:0], 8'h00} | {{24{in_name_byte[7]}}, in_name_byte};
  assign len_inc = (len_r == 2'd3) ? len_r : len_r + 2'd1;

  always_comb begin
    case (slot_r)
      2'd0:    word_pad = {word_sh[7:0], 24'h000000};
      2'd1:    word_pad = {word_sh[15:0], 16'h0000};
      2'd2:    word_pad = {word_sh[23:0], 8'h00};
      default: word_pad = word_sh;
    endcase
  end

  assign do_fold   = in_last_byte || (slot_r == 2'd3);
  assign fold_word = in_last_byte ? word_pad : word_sh;

  assign acc_first_f  = to_second_r ? acc_first_r  : (acc_first_r ^ fold_word);
  assign acc_second_f = to_second_r ? (acc_second_r ^ fold_word) : acc_second_r;

  assign job_push       = accept && in_last_byte;
  assign job.acc_a      = acc_first_f;
  assign job.acc_b      = acc_second_f;
  assign job.short_name = (len_inc <= 2'(dnh_pkg::ShortLen));

  always_comb begin
    acc_first_nxt  = acc_first_r;
    acc_second_nxt = acc_second_r;
    word_nxt       = word_r;
    slot_nxt       = slot_r;
    to_second_nxt  = to_second_r;
    len_nxt        = len_r;
    if (accept) begin
      if (in_last_byte) begin
        // End of name: start the next one from scratch.
        acc_first_nxt  = '0;
        acc_second_nxt = '0;
        word_nxt       = '0;
        slot_nxt       = '0;
        to_second_nxt  = 1'b0;
        len_nxt        = '0;
      end else begin
        len_nxt = len_inc;
        if (do_fold) begin
          acc_first_nxt  = acc_first_f;
          acc_second_nxt = acc_second_f;
          to_second_nxt  = !to_second_r;
          word_nxt       = '0;
          slot_nxt       = '0;
        end else begin
          word_nxt = word_sh;
          slot_nxt = slot_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_first_r  <= '0;
      acc_second_r <= '0;
      word_r       <= '0;
      slot_r       <= '0;
      to_second_r  <= 1'b0;
      len_r        <= '0;
    end else begin
      acc_first_r  <= acc_first_nxt;
      acc_second_r <= acc_second_nxt;
      word_r       <= word_nxt;
      slot_r       <= slot_nxt;
      to_second_r  <= to_second_nxt;
      len_r        <= len_nxt;
    end
  end

endmodule

>>> hdl/dnh_fifo.sv
// ----------------------------------------------------------------------------
// dnh_fifo: job queue
// Small queue of finished names between the packer and the mixing stage.
// ----------------------------------------------------------------------------
module dnh_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  dnh_pkg::job_t din,
  output logic          full,
  input  logic          pop,
  output dnh_pkg::job_t dout,
  output logic          empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  dnh_pkg::job_t mem [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

>>> hdl/dnh_back.sv
// ----------------------------------------------------------------------------
// dnh_back: mixing stage
// Runs the seven-step mix chain on one job, one step per cycle, and holds
// the folded 16-bit hash in an output register until it is taken.
// ----------------------------------------------------------------------------
module dnh_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dnh_pkg::job_t              job,
  input  logic                       job_empty,
  output logic                       job_pop,
  output logic                       empty,
  input  logic                       pop,
  output logic [dnh_pkg::HashW-1:0]  out_hash_value
);

  dnh_pkg::back_state_t state_r, state_nxt;

  logic [dnh_pkg::WordW-1:0] t_r, t_nxt;
  logic [dnh_pkg::WordW-1:0] a_r, b_r;
  logic                      short_r;
  logic [dnh_pkg::StepW-1:0] step_r, step_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [dnh_pkg::HashW-1:0] hash_r;

  logic                      load_out;
  logic                      last_step;
  logic [dnh_pkg::WordW-1:0] add_term;
  logic [dnh_pkg::WordW-1:0] t_mix;
  logic [dnh_pkg::HashW-1:0] hash_fold;

  assign last_step = (step_r == dnh_pkg::StepW'(dnh_pkg::MixSteps - 1));

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dnh_pkg::BK_IDLE: if (!job_empty) state_nxt = dnh_pkg::BK_RUN;
      dnh_pkg::BK_RUN:  if (last_step) state_nxt = dnh_pkg::BK_DONE;
      dnh_pkg::BK_DONE: if (!out_valid_r || pop) state_nxt = dnh_pkg::BK_IDLE;
      default:          state_nxt = dnh_pkg::BK_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    job_pop  = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      dnh_pkg::BK_IDLE: job_pop  = !job_empty;
      dnh_pkg::BK_RUN:  ;
      dnh_pkg::BK_DONE: load_out = !out_valid_r || pop;
      default:          ;
    endcase
  end

  always_comb begin
    case (step_r)
      3'd0:    add_term = {8'h00, a_r[31:8]};
      3'd1:    add_term = {16'h0000, a_r[31:16]};
      3'd2:    add_term = {24'h000000, a_r[31:24]};
      3'd3:    add_term = b_r;
      3'd4:    add_term = {8'h00, b_r[31:8]};
      3'd5:    add_term = {16'h0000, b_r[31:16]};
      default: add_term = {24'h000000, b_r[31:24]};
    endcase
  end

  // t * 7 + add - 1, modulo 2^32.
  assign t_mix     = ({t_r[28:0], 3'b000} - t_r) + add_term - 32'd1;
  assign hash_fold = short_r ? '0 : (t_r[15:0] | t_r[31:16]);

  always_comb begin
    t_nxt    = t_r;
    step_nxt = step_r;
    if (job_pop) begin
      t_nxt    = job.acc_a - 32'd1;
      step_nxt = '0;
    end else if (state_r == dnh_pkg::BK_RUN) begin
      t_nxt    = t_mix;
      step_nxt = step_r + dnh_pkg::StepW'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    t_r    <= t_nxt;
    step_r <= step_nxt;
    if (job_pop) begin
      a_r     <= job.acc_a;
      b_r     <= job.acc_b;
      short_r <= job.short_name;
    end
    if (load_out) begin
      hash_r <= hash_fold;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dnh_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign empty          = !out_valid_r;
  assign out_hash_value = hash_r;

endmodule

>>> hdl/dir_name_hash16.sv
// ----------------------------------------------------------------------------
// dir_name_hash16: streaming 16-bit directory name hash
// Name bytes go in one per item; one hash comes out per name.
// ----------------------------------------------------------------------------
// Input channel: drive in_name_byte and in_last_byte with push high; the byte
//   is taken at a clock edge where push is high and full is low. Raise
//   in_last_byte on the final byte of each name.
// Result channel: while empty is low, out_hash_value holds the hash of the
//   oldest finished name; raise pop to take it. Names of two bytes or fewer
//   hash to zero. Bytes that are not final give no result.
// Throughput: one byte per cycle in the packer while full is low. The mixing
//   stage mixes one name at a time (load, seven mix steps, write-out) and
//   takes the next only when done, so names arriving faster are paced by
//   the mixer; the job queue of JOB_DEPTH names absorbs short bursts.
// Path: the job of a name enters the queue with its final byte; the mixer
//   loads it, runs the mix steps and folds the hash into the result register.
// Stall: while the result waits, the mixer holds its finished job, the job
//   queue fills, and full rises only once the queue has no room; bytes that
//   are not final are still taken only while full is low.
// Reset: synchronous, active low; clears the packer, empties the queue and
//   drops any waiting result. No clearing pass is needed.
// ----------------------------------------------------------------------------
module dir_name_hash16 #(
  parameter int unsigned JOB_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_name_byte,
  input  logic        in_last_byte,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] out_hash_value
);

  // Finished names travel from the packer to the mixer through the queue.
  dnh_pkg::job_t job_in;
  dnh_pkg::job_t job_out;
  logic          job_push;
  logic          job_full;
  logic          job_pop;
  logic          job_empty;

  // Pack bytes, fold words, and hand over a name on its last byte.
  dnh_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (push),
    .full         (full),
    .in_name_byte (in_name_byte),
    .in_last_byte (in_last_byte),
    .job_push     (job_push),
    .job          (job_in),
    .job_full     (job_full)
  );

  // Decouple the packer from the mixer.
  dnh_fifo #(
    .DEPTH (JOB_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (job_push),
    .din   (job_in),
    .full  (job_full),
    .pop   (job_pop),
    .dout  (job_out),
    .empty (job_empty)
  );

  // Mix one name at a time and hold the result until popped.
  dnh_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job            (job_out),
    .job_empty      (job_empty),
    .job_pop        (job_pop),
    .empty          (empty),
    .pop            (pop),
    .out_hash_value (out_hash_value)
  );

`ifndef SYNTHESIS
  // The packer never hands over a name the queue cannot hold.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |-> !job_full)
    else $error("job handed over while queue is full");

  // A handed-over name is in the queue on the next cycle.
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    job_push |=> !job_empty)
    else $error("job queue empty right after a handover");

  // The mixer only takes a job that is there.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> !job_empty)
    else $error("mixer took a job from an empty queue");
`endif

endmodule
